// ----- hw/rtl/hsr_pkg.sv -----
// Shared constants, types and the control program for the Heron square root core.
// Used by hsr_div, hsr_seq, heron_square_root_core and hsr_checker; depends on nothing.
package hsr_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int MAX_ITER   = 64;
	localparam int WORD_W     = 32;
	localparam int TOL_W      = FRAC_BITS + 1;
	localparam int DIVIDEND_W = WORD_W + FRAC_BITS;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
	localparam int COUNT_W    = $clog2(MAX_ITER + 1);
	localparam int PC_W       = 3;

	typedef logic [PC_W-1:0] pc_t;

	typedef enum logic [2:0] {
		COND_NEXT        = 3'd0,
		COND_ALWAYS      = 3'd1,
		COND_NO_WORD     = 3'd2,
		COND_DIV_BUSY    = 3'd3,
		COND_MORE        = 3'd4,
		COND_OUT_BLOCKED = 3'd5
	} cond_t;

	// Program addresses
	localparam pc_t PC_IDLE  = 3'd0;
	localparam pc_t PC_START = 3'd1;
	localparam pc_t PC_DIV   = 3'd2;
	localparam pc_t PC_AVG   = 3'd3;
	localparam pc_t PC_DIFF  = 3'd4;
	localparam pc_t PC_TEST  = 3'd5;
	localparam pc_t PC_OUT   = 3'd6;
	localparam pc_t PC_DONE  = 3'd7;

	typedef struct packed {
		logic  ld_in;
		logic  start_div;
		logic  do_avg;
		logic  do_diff;
		logic  do_out;
		cond_t cond;
		pc_t   target;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic div_busy;
		logic more;
		logic out_blocked;
	} status_t;

	function automatic ctrl_t rom_word(input pc_t pc);
		ctrl_t w;
		w = '{ld_in: 1'b0, start_div: 1'b0, do_avg: 1'b0, do_diff: 1'b0, do_out: 1'b0,
			cond: COND_NEXT, target: PC_IDLE};
		case (pc)
			PC_IDLE: begin
				w.ld_in  = 1'b1;
				w.cond   = COND_NO_WORD;
				w.target = PC_IDLE;
			end
			PC_START: begin
				w.start_div = 1'b1;
			end
			PC_DIV: begin
				w.cond   = COND_DIV_BUSY;
				w.target = PC_DIV;
			end
			PC_AVG: begin
				w.do_avg = 1'b1;
			end
			PC_DIFF: begin
				w.do_diff = 1'b1;
			end
			PC_TEST: begin
				w.cond   = COND_MORE;
				w.target = PC_START;
			end
			PC_OUT: begin
				w.do_out = 1'b1;
				w.cond   = COND_OUT_BLOCKED;
				w.target = PC_OUT;
			end
			PC_DONE: begin
				w.cond   = COND_ALWAYS;
				w.target = PC_IDLE;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = PC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ----- hw/rtl/heron_square_root_core.sv -----
// Heron square root core, top level: datapath registers and output register.
// Depends on hsr_pkg, hsr_seq and hsr_div.
//
//   channel | handshake            | word
//   --------+----------------------+-------------------------------------------------
//   input   | in_valid / in_stall  | value_in, tolerance
//   output  | out_valid / out_stall| step_count, root_estimate, last_difference, hit_limit
//
// An item runs n averaging steps (1..64); each step runs the bit-serial divider
// and the five sequencer steps START, DIV, AVG, DIFF and TEST.
// Reset clears the step counter and the output valid flag and sets the divider count to its idle value.
// A new word is taken while a finished result still waits in the output register;
// only the hand-over of the next result waits on out_stall.
module heron_square_root_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [hsr_pkg::WORD_W-1:0]     value_in,
	input  logic [hsr_pkg::TOL_W-1:0]      tolerance,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [hsr_pkg::COUNT_W-1:0]    step_count,
	output logic [hsr_pkg::WORD_W-1:0]     root_estimate,
	output logic [hsr_pkg::WORD_W-1:0]     last_difference,
	output logic                           hit_limit
);

	hsr_pkg::ctrl_t   ctrl;
	hsr_pkg::status_t status;

	logic [hsr_pkg::WORD_W-1:0]     x_q;
	logic [hsr_pkg::TOL_W-1:0]      eps_q;
	logic [hsr_pkg::WORD_W-1:0]     cur_q;
	logic [hsr_pkg::WORD_W-1:0]     prev_q;
	logic [hsr_pkg::WORD_W-1:0]     diff_q;
	logic [hsr_pkg::COUNT_W-1:0]    count_q;
	logic                           out_valid_q;

	logic [hsr_pkg::DIVIDEND_W-1:0] quot;
	logic [hsr_pkg::DIVIDEND_W-1:0] quot_eff;
	logic                           div_busy;
	logic [hsr_pkg::DIVIDEND_W:0]   sum;
	logic [hsr_pkg::DIVIDEND_W-1:0] half;
	logic [hsr_pkg::WORD_W-1:0]     avg_sat;
	logic                           over_eps;
	logic                           out_free;

	hsr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	hsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.start_div),
		.dividend ({x_q, hsr_pkg::FRAC_BITS'(0)}),
		.divisor  (cur_q),
		.quotient (quot),
		.busy     (div_busy)
	);

	// A zero estimate only comes from a zero input; its quotient counts as zero.
	assign quot_eff = (prev_q == '0) ? '0 : quot;
	assign sum      = {1'b0, hsr_pkg::DIVIDEND_W'(prev_q)} + {1'b0, quot_eff};
	assign half     = sum[hsr_pkg::DIVIDEND_W:1];
	assign avg_sat  = (half[hsr_pkg::DIVIDEND_W-1:hsr_pkg::WORD_W] != '0) ? '1
		: half[hsr_pkg::WORD_W-1:0];

	assign over_eps = (diff_q > hsr_pkg::WORD_W'(eps_q));
	assign out_free = !out_valid_q || !out_stall;

	assign status.in_valid    = in_valid;
	assign status.div_busy    = div_busy;
	assign status.more        = over_eps && (count_q < hsr_pkg::COUNT_W'(hsr_pkg::MAX_ITER));
	assign status.out_blocked = !out_free;

	assign in_stall  = !ctrl.ld_in;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.ld_in && in_valid) begin
			count_q <= '0;
		end else if (ctrl.start_div) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_in && in_valid) begin
			x_q   <= value_in;
			eps_q <= tolerance;
			cur_q <= value_in;
		end
		if (ctrl.start_div) begin
			prev_q <= cur_q;
		end
		if (ctrl.do_avg) begin
			cur_q <= avg_sat;
		end
		if (ctrl.do_diff) begin
			diff_q <= (prev_q >= cur_q) ? prev_q - cur_q : cur_q - prev_q;
		end
	end

	// Output register: drop the word once taken, load a new one when free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.do_out && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.do_out && out_free) begin
			step_count      <= count_q;
			root_estimate   <= cur_q;
			last_difference <= diff_q;
			hit_limit       <= over_eps;
		end
	end

endmodule

// ----- hw/rtl/hsr_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Depends on hsr_pkg for widths.
module hsr_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [hsr_pkg::DIVIDEND_W-1:0]    dividend,
	input  logic [hsr_pkg::WORD_W-1:0]        divisor,
	output logic [hsr_pkg::DIVIDEND_W-1:0]    quotient,
	output logic                              busy
);

	logic [hsr_pkg::WORD_W-1:0]     rem_q;
	logic [hsr_pkg::DIVIDEND_W-1:0] quo_q;
	logic [hsr_pkg::WORD_W-1:0]     divisor_q;
	logic [hsr_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [hsr_pkg::WORD_W:0]       trial;
	logic [hsr_pkg::WORD_W:0]       trial_sub;
	logic                           fits;

	assign busy      = (cnt_q != hsr_pkg::DIV_CNT_W'(hsr_pkg::DIVIDEND_W));
	assign quotient  = quo_q;
	assign trial     = {rem_q, quo_q[hsr_pkg::DIVIDEND_W-1]};
	assign fits      = (trial >= {1'b0, divisor_q});
	assign trial_sub = trial - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= hsr_pkg::DIV_CNT_W'(hsr_pkg::DIVIDEND_W);
		end else if (start) begin
			cnt_q <= '0;
		end else if (busy) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Dividend bits shift out at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (busy) begin
			rem_q <= fits ? trial_sub[hsr_pkg::WORD_W-1:0] : trial[hsr_pkg::WORD_W-1:0];
			quo_q <= {quo_q[hsr_pkg::DIVIDEND_W-2:0], fits};
		end
	end

endmodule

// ----- hw/rtl/hsr_seq.sv -----
// Microcode sequencer: step counter, program table lookup and conditional jumps.
// Depends on hsr_pkg for the control word, status struct and program.
module hsr_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  hsr_pkg::status_t status,
	output hsr_pkg::ctrl_t   ctrl
);

	hsr_pkg::pc_t pc_q;
	hsr_pkg::pc_t pc_d;
	logic         take;

	assign ctrl = hsr_pkg::rom_word(pc_q);

	always_comb begin
		case (ctrl.cond)
			hsr_pkg::COND_NEXT:        take = 1'b0;
			hsr_pkg::COND_ALWAYS:      take = 1'b1;
			hsr_pkg::COND_NO_WORD:     take = !status.in_valid;
			hsr_pkg::COND_DIV_BUSY:    take = status.div_busy;
			hsr_pkg::COND_MORE:        take = status.more;
			hsr_pkg::COND_OUT_BLOCKED: take = status.out_blocked;
			default:                   take = 1'b1;
		endcase
		pc_d = take ? ctrl.target : pc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= hsr_pkg::PC_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

// ----- hw/rtl/hsr_checker.sv -----
// Port-level checks for the Heron square root core, bound to the top level.
// Depends on hsr_pkg for widths and the iteration cap.
module hsr_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [hsr_pkg::WORD_W-1:0]     value_in,
	input  logic [hsr_pkg::TOL_W-1:0]      tolerance,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [hsr_pkg::COUNT_W-1:0]    step_count,
	input  logic [hsr_pkg::WORD_W-1:0]     root_estimate,
	input  logic [hsr_pkg::WORD_W-1:0]     last_difference,
	input  logic                           hit_limit
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(root_estimate)
			&& $stable(step_count))
		else $error("stalled result word changed or dropped");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> step_count != '0
			&& step_count <= hsr_pkg::COUNT_W'(hsr_pkg::MAX_ITER))
		else $error("step count out of range");

	a_limit_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit_limit |-> step_count == hsr_pkg::COUNT_W'(hsr_pkg::MAX_ITER))
		else $error("limit flag before iteration cap");

	a_new_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_stall)
		else $error("input open right after a result was posted");

	a_zero_root: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_estimate == '0 |-> last_difference == '0 && step_count == 7'd1)
		else $error("zero root with nonzero difference or extra steps");

endmodule

bind heron_square_root_core hsr_checker u_hsr_checker (.*);
